// File: rtl/b64d_pkg.sv
`default_nettype none

package b64d_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned SEXTET_W  = 6;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned BYTE_W    = 8;

    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

    localparam logic [SEXTET_W-1:0] LOWER_BASE = 6'd26;
    localparam logic [SEXTET_W-1:0] DIGIT_BASE = 6'd52;
    localparam logic [SEXTET_W-1:0] PLUS_VAL   = 6'd62;
    localparam logic [SEXTET_W-1:0] SLASH_VAL  = 6'd63;

    // one result item as it moves from the decoder to the output stage
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              string_done;
        logic              bad_input;
    } t_result;

    typedef struct packed {
        logic                ok;
        logic [SEXTET_W-1:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [CHAR_W-1:0] ch);
        t_sextet s;
        s.ok    = 1'b1;
        s.value = '0;
        if (ch >= CH_UA && ch <= CH_UZ) begin
            s.value = SEXTET_W'(ch - CH_UA);
        end else if (ch >= CH_LA && ch <= CH_LZ) begin
            s.value = SEXTET_W'(ch - CH_LA) + LOWER_BASE;
        end else if (ch >= CH_0 && ch <= CH_9) begin
            s.value = SEXTET_W'(ch - CH_0) + DIGIT_BASE;
        end else if (ch == CH_PLUS) begin
            s.value = PLUS_VAL;
        end else if (ch == CH_SLASH) begin
            s.value = SLASH_VAL;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/base64_stream_decoder.sv
// Channel | Dir | Signals                              | Content
// s       | in  | i_s_tvalid/o_s_tready/tdata/tuser/tlast | one character, has_char, end
// m       | out | o_m_tvalid/i_m_tready/tdata/tuser/tlast | decoded byte, flags, end
//
// One character is taken per clock while s is ready; its result (if any) is registered into the output stage.
// Decode and buffer update sit between the input handshake and the output register.
// A two-entry output stage (register plus skid) keeps s ready while one result waits.
// s stalls only while both output entries are full.
// i_rst_n is synchronous, active low; it clears the bit buffer, flags and output stage.
`default_nettype none

module base64_stream_decoder
    import b64d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [CHAR_W-1:0] i_s_tdata,   // [7:0] char_code
    input  wire logic              i_s_tuser,   // [0] has_char
    input  wire logic              i_s_tlast,   // end_of_string
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [BYTE_W-1:0]      o_m_tdata,   // [7:0] data_byte
    output logic [1:0]             o_m_tuser,   // [0] byte_valid, [1] bad_input
    output logic                   o_m_tlast    // string_done
);

    logic    take;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign take = i_s_tvalid && o_s_tready;

    b64d_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char      (i_s_tdata),
        .i_has_char  (i_s_tuser),
        .i_end       (i_s_tlast),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    b64d_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (take && res_valid),
        .i_res       (res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_res       (out_res)
    );

    assign o_m_tdata = out_res.data_byte;
    assign o_m_tuser = {out_res.bad_input, out_res.byte_valid};
    assign o_m_tlast = out_res.string_done;

endmodule

`default_nettype wire

// File: rtl/b64d_core.sv
`default_nettype none

module b64d_core
    import b64d_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_has_char,
    input  wire logic              i_end,
    output t_result                o_res,
    output logic                   o_res_valid
);

    logic [SEXTET_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_pad, n_pad;
    logic                r_err, n_err;

    t_sextet               sx;
    logic [CNT_W-1:0]      cnt_clamp;
    logic [CNT_W:0]        cnt_sum;
    logic [CNT_W-1:0]      cnt_left;
    logic [2*SEXTET_W-1:0] buf_bits;
    logic [2*SEXTET_W-1:0] buf_shift;
    logic [SEXTET_W:0]     keep_mask;
    logic                  got_byte;
    logic                  is_ws;

    always_comb begin
        sx        = sextet_of(i_char);
        is_ws     = (i_char == CH_LF) || (i_char == CH_CR) || (i_char == CH_SPACE);
        cnt_clamp = (r_cnt > CNT_W'(6)) ? CNT_W'(6) : r_cnt;
        cnt_sum   = {1'b0, cnt_clamp} + (CNT_W+1)'(SEXTET_W);
        buf_bits  = {r_bits, sx.value};
        got_byte  = cnt_sum >= (CNT_W+1)'(BYTE_W);
        cnt_left  = got_byte ? CNT_W'(cnt_sum - (CNT_W+1)'(BYTE_W)) : CNT_W'(cnt_sum);
        buf_shift = buf_bits >> cnt_left;
        keep_mask = (SEXTET_W+1)'(((SEXTET_W+2)'(1) << cnt_left) - (SEXTET_W+2)'(1));

        n_bits = r_bits;
        n_cnt  = r_cnt;
        n_pad  = r_pad;
        n_err  = r_err;

        o_res             = '0;
        o_res_valid       = 1'b0;

        if (i_has_char && !is_ws) begin
            if (i_char == CH_EQ) begin
                n_pad = 1'b1;
            end else if (!sx.ok || r_pad) begin
                n_err = 1'b1;
            end else if (!r_err) begin
                n_bits = buf_bits[SEXTET_W-1:0] & keep_mask[SEXTET_W-1:0];
                n_cnt  = cnt_left;
                if (got_byte) begin
                    o_res.data_byte  = buf_shift[BYTE_W-1:0];
                    o_res.byte_valid = 1'b1;
                end
            end
        end

        o_res.string_done = i_end;
        o_res.bad_input   = i_end && n_err;
        o_res_valid       = o_res.byte_valid || i_end;

        // end of string: drop leftover bits and start clean
        if (i_end) begin
            n_bits = '0;
            n_cnt  = '0;
            n_pad  = 1'b0;
            n_err  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_cnt  <= '0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_take) begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_cnt_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] == 1'b0)
        else $error("pending count is odd");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_end) |=> (r_cnt == '0 && !r_pad && !r_err && r_bits == '0))
        else $error("state not cleared after end of string");

    a_bad_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.bad_input) |-> (o_res.string_done && !o_res.byte_valid))
        else $error("error flag without end marker or with a byte");
`endif

endmodule

`default_nettype wire

// File: rtl/b64d_obuf.sv
`default_nettype none

module b64d_obuf
    import b64d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_pop_ready,
    output t_result      o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && i_pop_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload: advance from skid, or load the new transfer where it lands
    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end else if (i_push && (pop || !r_out_valid)) begin
            r_out <= i_res;
        end
        if (i_push && r_out_valid && !pop) begin
            r_skid <= i_res;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds data while output is empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_skid_valid))
        else $error("push into full buffer");
`endif

endmodule

`default_nettype wire
